// ----- hw/rtl/kss_pkg.sv -----
package kss_pkg;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 5;

	typedef logic [FUNC_W-1:0]          func_t;
	typedef logic signed [KEY_W-1:0]    key_t;
	typedef logic signed [VAL_W-1:0]    val_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic [OCC_W-1:0]           occ_t;

	// operation codes on the request channel (the unused code acts as a peek)
	localparam func_t FUNC_PUSH = 2'd0;
	localparam func_t FUNC_POP  = 2'd1;
	localparam func_t FUNC_PEEK = 2'd2;

	// result status codes
	localparam status_t ST_PUSHED    = 3'd0;
	localparam status_t ST_DUPLICATE = 3'd1;
	localparam status_t ST_FULL      = 3'd2;
	localparam status_t ST_POPPED    = 3'd3;
	localparam status_t ST_UNDERFLOW = 3'd4;
	localparam status_t ST_PEEKED    = 3'd5;

endpackage

// ----- hw/rtl/kss_req_if.sv -----
interface kss_req_if
	import kss_pkg::*;
;
	logic  valid;
	logic  ready;
	func_t func;
	key_t  entry_key;
	val_t  entry_value;

	modport source (output valid, output func, output entry_key, output entry_value,
		input ready);
	modport sink (input valid, input func, input entry_key, input entry_value,
		output ready);
endinterface

// ----- hw/rtl/kss_rsp_if.sv -----
interface kss_rsp_if
	import kss_pkg::*;
;
	logic    valid;
	logic    ready;
	status_t status;
	logic    found;
	key_t    result_key;
	val_t    result_value;
	occ_t    occupancy;

	modport source (output valid, output status, output found, output result_key,
		output result_value, output occupancy, input ready);
	modport sink (input valid, input status, input found, input result_key,
		input result_value, input occupancy, output ready);
endinterface

// ----- hw/rtl/keyed_stack_with_search.sv -----
// Keyed LIFO stack: one request at a time through a single memory read port.
// Push and peek compare one stored entry per cycle, top to bottom, until a match or
// the bottom; pop reads only the top entry, and any operation on an empty stack skips
// the scan. A result waits in S_FINISH until the output register is free; a new request
// is taken while the previous result still waits in the output register. Reset (arst_n
// low) empties the stack and drops any pending result.
module keyed_stack_with_search
	import kss_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	kss_req_if.sink   req,
	kss_rsp_if.source rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;
	typedef enum logic [1:0] {OP_PUSH, OP_POP, OP_PEEK} op_t;

	// stack storage, entry 0 at the bottom
	key_t key_mem [STACK_DEPTH];
	val_t val_mem [STACK_DEPTH];

	state_t         state_q;
	op_t            op_q;
	key_t           key_q;
	val_t           val_q;
	logic [LW-1:0]  fill_q;
	logic [AW-1:0]  scan_idx_q;
	logic           issue_q;
	logic           rd_valid_q;
	key_t           rd_key_q;
	val_t           rd_val_q;
	status_t        res_status_q;
	logic           res_found_q;
	key_t           res_key_q;
	val_t           res_val_q;
	logic           out_valid_q;
	status_t        out_status_q;
	logic           out_found_q;
	key_t           out_key_q;
	val_t           out_val_q;
	occ_t           out_occ_q;

	op_t              op_in;
	logic             req_fire;
	logic             fill_empty;
	logic             fill_full;
	logic [LW-1:0]    fill_dec;
	logic [LW-1:0]    fill_inc;
	logic [LW+OCC_W-1:0] occ_ext;
	logic             rd_en;
	logic             key_match;
	logic             scan_end;
	logic             mem_we;
	key_t             mem_wkey;
	val_t             mem_wval;
	logic             rsp_free;

	// decode the operation code
	always_comb begin
		case (req.func)
			FUNC_PUSH: op_in = OP_PUSH;
			FUNC_POP:  op_in = OP_POP;
			default:   op_in = OP_PEEK;
		endcase
	end

	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign fill_empty = (fill_q == '0);
	assign fill_full  = (fill_q == LW'(STACK_DEPTH));
	assign fill_dec   = fill_q - LW'(1);
	assign fill_inc   = fill_q + LW'(1);
	assign occ_ext    = {{OCC_W{1'b0}}, fill_q};

	// scan: issue one read per cycle, compare the returned entry in the following cycle
	assign rd_en     = (state_q == S_SCAN) && issue_q;
	assign key_match = rd_valid_q && ((op_q == OP_POP) || (rd_key_q == key_q));
	assign scan_end  = rd_valid_q && !issue_q;

	// store a new pair on an empty stack at once, else after a clean scan if space remains
	assign mem_we = (req_fire && (op_in == OP_PUSH) && fill_empty)
		|| ((state_q == S_SCAN) && !key_match && scan_end && (op_q == OP_PUSH) && !fill_full);
	assign mem_wkey = (state_q == S_IDLE) ? req.entry_key : key_q;
	assign mem_wval = (state_q == S_IDLE) ? req.entry_value : val_q;

	assign rsp_free = !out_valid_q || rsp.ready;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[fill_q[AW-1:0]] <= mem_wkey;
			val_mem[fill_q[AW-1:0]] <= mem_wval;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[scan_idx_q];
			rd_val_q <= val_mem[scan_idx_q];
		end
	end

	// sequencer, fill level and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_PUSH;
			key_q        <= '0;
			val_q        <= '0;
			fill_q       <= '0;
			scan_idx_q   <= '0;
			issue_q      <= 1'b0;
			rd_valid_q   <= 1'b0;
			res_status_q <= ST_PUSHED;
			res_found_q  <= 1'b0;
			res_key_q    <= '0;
			res_val_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_PUSHED;
			out_found_q  <= 1'b0;
			out_key_q    <= '0;
			out_val_q    <= '0;
			out_occ_q    <= '0;
		end else begin
			// drop the result once transferred
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q        <= op_in;
						key_q       <= req.entry_key;
						val_q       <= req.entry_value;
						scan_idx_q  <= fill_dec[AW-1:0];
						issue_q     <= 1'b1;
						rd_valid_q  <= 1'b0;
						res_found_q <= 1'b0;
						res_key_q   <= '0;
						res_val_q   <= '0;
						if (fill_empty) begin
							case (op_in)
								OP_PUSH: begin
									res_status_q <= ST_PUSHED;
									fill_q       <= fill_inc;
								end
								OP_POP:  res_status_q <= ST_UNDERFLOW;
								default: res_status_q <= ST_PEEKED;
							endcase
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					// advance the read pointer towards the bottom
					if (rd_en) begin
						issue_q    <= (scan_idx_q != '0) && (op_q != OP_POP);
						scan_idx_q <= scan_idx_q - AW'(1);
					end
					rd_valid_q <= rd_en;

					if (key_match) begin
						case (op_q)
							OP_PUSH: res_status_q <= ST_DUPLICATE;
							OP_POP: begin
								res_status_q <= ST_POPPED;
								res_key_q    <= rd_key_q;
								res_val_q    <= rd_val_q;
								fill_q       <= fill_dec;
							end
							default: begin
								res_status_q <= ST_PEEKED;
								res_found_q  <= 1'b1;
								res_key_q    <= rd_key_q;
								res_val_q    <= rd_val_q;
							end
						endcase
						state_q <= S_FINISH;
					end else if (scan_end) begin
						case (op_q)
							OP_PUSH: begin
								if (fill_full) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_PUSHED;
									fill_q       <= fill_inc;
								end
							end
							default: res_status_q <= ST_PEEKED;
						endcase
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					// hold until the output register is free
					if (rsp_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_key_q    <= res_key_q;
						out_val_q    <= res_val_q;
						out_occ_q    <= occ_ext[OCC_W-1:0];
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.found        = out_found_q;
	assign rsp.result_key   = out_key_q;
	assign rsp.result_value = out_val_q;
	assign rsp.occupancy    = out_occ_q;

	// fill level never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(STACK_DEPTH))
		else $error("fill level beyond capacity");

	// a full refusal only when the stack really is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && (res_status_q == ST_FULL) |-> fill_full)
		else $error("full status with free space");

	// no scan runs over an empty stack
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !fill_empty)
		else $error("scan on empty stack");

	// a pop removes exactly one entry
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && key_match && (op_q == OP_POP) |=> fill_q == $past(fill_dec))
		else $error("pop did not shrink the stack by one");

endmodule
